[rtl/slss_pkg.sv]
package slss_pkg;

  // table and offer limits per scanline
  localparam int MAX_SPRITES = 10;
  localparam int MAX_OFFERS  = 40;

  localparam int IDX_W = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
  localparam int CNT_W = $clog2(MAX_SPRITES + 1);
  localparam int OFF_W = $clog2(MAX_OFFERS + 1);

  // screening limits
  localparam logic [7:0] Y_LIMIT    = 8'd160;
  localparam logic [7:0] X_LIMIT    = 8'd168;
  localparam logic [8:0] Y_BIAS     = 9'd16;
  localparam logic [8:0] SHORT_ROWS = 9'd8;
  localparam logic [8:0] TALL_ROWS  = 9'd16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRITE_ENABLE = 2'd0,
    REG_TALL_SPRITES  = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_OFFER = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] tile;
    logic [7:0] attr;
  } obj_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] line;
    obj_t       obj;
    logic [3:0] slot;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] sprite_count;
    logic       slot_valid;
    obj_t       obj;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic commit;
  } dp_cmd_t;

endpackage

[rtl/slss_in_if.sv]
interface slss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] line;
  logic [7:0] obj_y;
  logic [7:0] obj_x;
  logic [7:0] obj_tile;
  logic [7:0] obj_attr;
  logic [3:0] slot;

  modport source (output valid, cmd, line, obj_y, obj_x, obj_tile, obj_attr, slot,
                  input ready);
  modport sink (input valid, cmd, line, obj_y, obj_x, obj_tile, obj_attr, slot,
                output ready);
endinterface

[rtl/slss_out_if.sv]
interface slss_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [3:0] sprite_count;
  logic       slot_valid;
  logic [7:0] out_y;
  logic [7:0] out_x;
  logic [7:0] out_tile;
  logic [7:0] out_attr;

  modport source (output valid, accepted, sprite_count, slot_valid,
                         out_y, out_x, out_tile, out_attr,
                  input ready);
  modport sink (input valid, accepted, sprite_count, slot_valid,
                      out_y, out_x, out_tile, out_attr,
                output ready);
endinterface

[rtl/slss_cfg_if.sv]
interface slss_cfg_if
  import slss_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/slss_ctrl.sv]
module slss_ctrl
  import slss_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t dp_cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  // one item in flight; the result register frees the input side
  assign in_ready       = (state_r == S_IDLE);
  assign dp_cmd.load_in = in_valid && in_ready;
  assign dp_cmd.commit  = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid      = out_valid_r;

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (dp_cmd.load_in) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (dp_cmd.commit) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (dp_cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/slss_datapath.sv]
module slss_datapath
  import slss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               dp_cmd,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               result
);

  in_item_t          in_r;
  result_t           res_r;
  result_t           res_nxt;
  obj_t              table_r [MAX_SPRITES];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [OFF_W-1:0]  offers_r;
  logic [OFF_W-1:0]  offers_nxt;
  logic              enable_r;
  logic              tall_r;
  logic [MAX_SPRITES-1:0] lt;
  logic              counted;
  logic              visible;
  logic              do_insert;
  logic              do_clear;
  logic              rd_valid;
  logic [8:0]        y9;
  logic [8:0]        ln9;
  logic [8:0]        rows;

  assign result = res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      tall_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPRITE_ENABLE: enable_r <= cfg_data[0];
        REG_TALL_SPRITES:  tall_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input item register
  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) in_r <= in_item;
  end

  // offer screening
  always_comb begin
    y9      = {1'b0, in_r.obj.y};
    ln9     = {1'b0, in_r.line};
    rows    = tall_r ? TALL_ROWS : SHORT_ROWS;
    counted = (in_r.cmd == CMD_OFFER) && enable_r &&
              (offers_r < OFF_W'(MAX_OFFERS)) && (count_r < CNT_W'(MAX_SPRITES));
    visible = (in_r.obj.x != 8'd0) && (in_r.obj.x < X_LIMIT) &&
              (in_r.obj.y != 8'd0) && (in_r.obj.y < Y_LIMIT) &&
              !((y9 < Y_BIAS) && (ln9 + y9 >= Y_BIAS)) &&
              !(ln9 + Y_BIAS < y9) &&
              !(ln9 + Y_BIAS >= y9 + rows);
    do_insert = counted && visible;
    do_clear  = (in_r.cmd == CMD_START);
  end

  // stored entries ahead of the new one (strictly smaller x)
  always_comb begin
    for (int i = 0; i < MAX_SPRITES; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && (table_r[i].x < in_r.obj.x);
    end
  end

  // counters and result
  always_comb begin
    count_nxt  = count_r;
    offers_nxt = offers_r;
    if (do_clear) begin
      count_nxt  = '0;
      offers_nxt = '0;
    end else begin
      if (counted) offers_nxt = offers_r + OFF_W'(1);
      if (do_insert) count_nxt = count_r + CNT_W'(1);
    end
    rd_valid = (in_r.cmd == CMD_READ) && (5'(in_r.slot) < 5'(count_r));
    res_nxt.accepted     = do_insert;
    res_nxt.sprite_count = 4'(count_nxt);
    res_nxt.slot_valid   = rd_valid;
    res_nxt.obj          = rd_valid ? table_r[in_r.slot[IDX_W-1:0]] : '0;
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      offers_r <= '0;
    end else if (dp_cmd.commit) begin
      count_r  <= count_nxt;
      offers_r <= offers_nxt;
    end
  end

  // sorted insert: entries at or past the slot move up by one
  always_ff @(posedge clk) begin
    if (dp_cmd.commit && do_insert) begin
      if (!lt[0]) table_r[0] <= in_r.obj;
      for (int i = 1; i < MAX_SPRITES; i++) begin
        if (!lt[i]) begin
          table_r[i] <= lt[i-1] ? in_r.obj : table_r[i-1];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (dp_cmd.commit) res_r <= res_nxt;
  end

endmodule

[rtl/sprite_line_select_sort.sv]
// Per-scanline sprite selector with an x-sorted table.
// Channels: in_ch takes commands (start line, offer object entry, read slot),
// out_ch returns one result per command, cfg_ch writes sprite_enable (index 0)
// and tall_sprites (index 1). All transfers complete when valid and ready are
// both high at a rising clk edge; cfg_ch is always ready.
// The command is captured in an input register and the result is registered;
// the block takes no new command until the previous one leaves its execute
// state, where screening, the parallel compare against all stored x values and
// the shift insert are done.
// A command is taken while the previous result still waits in the output
// register; if that result is still not taken when the next one is ready,
// the block waits in its execute state and accepts nothing new.
// Reset (rst_n low, synchronous) empties the table, clears the offer count,
// disables sprites and selects 8-row objects. No clearing pass is needed;
// table slots at or beyond the entry count read back as zero.
module sprite_line_select_sort
  import slss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  slss_cfg_if.sink   cfg_ch,
  slss_in_if.sink    in_ch,
  slss_out_if.source out_ch
);

  dp_cmd_t  dp_cmd;
  in_item_t in_item;
  result_t  result;
  logic     out_valid;

  // configuration always ready
  assign cfg_ch.ready = 1'b1;

  // pack input payload
  assign in_item.cmd      = in_ch.cmd;
  assign in_item.line     = in_ch.line;
  assign in_item.obj.y    = in_ch.obj_y;
  assign in_item.obj.x    = in_ch.obj_x;
  assign in_item.obj.tile = in_ch.obj_tile;
  assign in_item.obj.attr = in_ch.obj_attr;
  assign in_item.slot     = in_ch.slot;

  slss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd)
  );

  slss_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .result    (result)
  );

  // unpack result payload
  assign out_ch.valid        = out_valid;
  assign out_ch.accepted     = result.accepted;
  assign out_ch.sprite_count = result.sprite_count;
  assign out_ch.slot_valid   = result.slot_valid;
  assign out_ch.out_y        = result.obj.y;
  assign out_ch.out_x        = result.obj.x;
  assign out_ch.out_tile     = result.obj.tile;
  assign out_ch.out_attr     = result.obj.attr;

endmodule

[tb/sprite_line_select_sort_test.sv]
`timescale 1ns / 100ps

module sprite_line_select_sort_test;
  import slss_pkg::*;

  // index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // command code the block does not define
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  slss_cfg_if cfg_ch ();
  slss_in_if  in_ch ();
  slss_out_if out_ch ();

  sprite_line_select_sort dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // line table as the block should hold it
  obj_t    line_table [MAX_SPRITES];
  int      line_count;
  int      offers_counted;
  bit      sprites_on;
  bit      tall_mode;
  result_t expected_results [$];

  int mismatch_count;
  int items_sent;
  int offers_inserted;
  int slots_read;
  int stall_run;
  int longest_stall;
  bit idle_on = 1'b1;
  int hold_cycles;

  // screen, insert or read one command and return the result it should give
  function automatic result_t select_and_sort(input in_item_t it);
    result_t r;
    int      pos;
    int      top;
    int      rows;
    bit      on_line;
    r = '0;
    case (it.cmd)
      CMD_START: begin
        foreach (line_table[i]) line_table[i] = '0;
        line_count     = 0;
        offers_counted = 0;
      end
      CMD_OFFER: begin
        if (sprites_on && offers_counted < MAX_OFFERS && line_count < MAX_SPRITES) begin
          offers_counted++;
          top  = int'(it.obj.y) - 16;
          rows = tall_mode ? 16 : 8;
          on_line = 1'b1;
          if (it.obj.y == 0 || it.obj.y >= Y_LIMIT) on_line = 1'b0;
          if (it.obj.y < 16 && int'(it.line) >= 16 - int'(it.obj.y)) on_line = 1'b0;
          if (int'(it.line) < top || int'(it.line) >= top + rows) on_line = 1'b0;
          if (it.obj.x != 0 && it.obj.x < X_LIMIT && on_line) begin
            // new entry goes ahead of equal x
            pos = 0;
            while (pos < line_count && line_table[pos].x < it.obj.x) pos++;
            for (int k = line_count; k > pos; k--) line_table[k] = line_table[k-1];
            line_table[pos] = it.obj;
            line_count++;
            r.accepted = 1'b1;
            offers_inserted++;
          end
        end
      end
      CMD_READ: begin
        if (it.slot < line_count) begin
          r.slot_valid = 1'b1;
          r.obj        = line_table[it.slot];
          slots_read++;
        end
      end
      default: ;
    endcase
    r.sprite_count = 4'(line_count);
    return r;
  endfunction

  // any command with random fields inside the stated ranges
  function automatic in_item_t rand_item();
    in_item_t it;
    it.cmd  = 2'($urandom_range(0, 3));
    it.line = 8'($urandom_range(0, 153));
    it.obj  = $urandom;
    it.slot = 4'($urandom_range(0, 9));
    return it;
  endfunction

  function automatic in_item_t offer(input logic [7:0] ln, input logic [7:0] y,
                                     input logic [7:0] x);
    in_item_t it;
    it       = rand_item();
    it.cmd   = CMD_OFFER;
    it.line  = ln;
    it.obj.y = y;
    it.obj.x = x;
    return it;
  endfunction

  function automatic in_item_t command(input logic [1:0] cmd, input logic [3:0] slot);
    in_item_t it;
    it      = rand_item();
    it.cmd  = cmd;
    it.slot = slot;
    return it;
  endfunction

  // one input transfer, valid stays high for a following item
  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= it.cmd;
    in_ch.line     <= it.line;
    in_ch.obj_y    <= it.obj.y;
    in_ch.obj_x    <= it.obj.x;
    in_ch.obj_tile <= it.obj.tile;
    in_ch.obj_attr <= it.obj.attr;
    in_ch.slot     <= it.slot;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(select_and_sort(it));
    items_sent++;
  endtask

  // block idle: no input offered and every result taken
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register writes between phases only
  task automatic configure(input bit en, input bit tall, input bit poke_unused = 1'b0);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_SPRITE_ENABLE;
    cfg_ch.data  <= en;
    do @(posedge clk); while (!cfg_ch.ready);
    sprites_on = en;
    cfg_ch.index <= REG_TALL_SPRITES;
    cfg_ch.data  <= tall;
    do @(posedge clk); while (!cfg_ch.ready);
    tall_mode = tall;
    if (poke_unused) begin
      cfg_ch.index <= REG_UNUSED;
      cfg_ch.data  <= 1'b1;
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // start, a run of offers biased toward visible objects, then slot reads
  task automatic run_line_sequence();
    logic [7:0] ln;
    logic [7:0] tie_x [4];
    int         n_offers;
    int         vis_pct;
    in_item_t   it;
    ln       = 8'($urandom_range(0, 153));
    n_offers = $urandom_range(0, 46);
    vis_pct  = $urandom_range(10, 95);
    foreach (tie_x[i]) tie_x[i] = 8'($urandom_range(1, 167));
    send_item(command(CMD_START, 4'd0));
    repeat (n_offers) begin
      it      = rand_item();
      it.cmd  = CMD_OFFER;
      it.line = ln;
      if ($urandom_range(1, 100) <= vis_pct) begin
        it.obj.y = ln + 8'd16 - 8'($urandom_range(0, tall_mode ? 15 : 7));
        if ($urandom_range(0, 2) == 0) it.obj.x = tie_x[$urandom_range(0, 3)];
        else it.obj.x = 8'($urandom_range(1, 167));
      end
      send_item(it);
      if ($urandom_range(0, 9) == 0) send_item(command(CMD_READ, 4'($urandom_range(0, 9))));
    end
    repeat ($urandom_range(2, 10)) send_item(command(CMD_READ, 4'($urandom_range(0, 9))));
  endtask

  // offers with sprites off, also after a write to an unused index
  task automatic test_disabled_offers();
    send_item(offer(8'd20, 8'd36, 8'd50));
    send_item(command(CMD_READ, 4'd0));
    configure(1'b0, 1'b0, 1'b1);
    send_item(offer(8'd20, 8'd36, 8'd50));
  endtask

  // each reject reason and the row boundaries with 8-row objects
  task automatic test_screening_edges();
    configure(1'b1, 1'b0);
    send_item(command(CMD_START, 4'd9));
    send_item(offer(8'd20, 8'd0,   8'd50));
    send_item(offer(8'd20, 8'd160, 8'd50));
    send_item(offer(8'd20, 8'd36,  8'd0));
    send_item(offer(8'd20, 8'd36,  8'd168));
    send_item(offer(8'd19, 8'd36,  8'd60));
    send_item(offer(8'd28, 8'd36,  8'd60));
    send_item(offer(8'd20, 8'd36,  8'd167));
    send_item(offer(8'd27, 8'd36,  8'd1));
    // objects that start above the top edge, rejected then accepted
    send_item(offer(8'd5,  8'd8,   8'd40));
    send_item(offer(8'd1,  8'd10,  8'd40));
    send_item(command(CMD_READ, 4'd0));
    send_item(command(CMD_READ, 4'd2));
    send_item(command(CMD_READ, 4'd3));
  endtask

  // 16-row objects, equal x ordering, byte extremes and the undefined code
  task automatic test_tall_rows_and_ties();
    in_item_t it;
    configure(1'b1, 1'b1);
    send_item(command(CMD_START, 4'd0));
    it = offer(8'd35, 8'd36, 8'd80);
    it.obj.tile = 8'h00;
    it.obj.attr = 8'hff;
    send_item(it);
    send_item(offer(8'd36, 8'd36, 8'd80));
    it = offer(8'd153, 8'd159, 8'd80);
    it.obj.tile = 8'hff;
    it.obj.attr = 8'h00;
    send_item(it);
    send_item(command(CMD_READ, 4'd0));
    send_item(command(CMD_READ, 4'd1));
    send_item(command(CMD_UNDEF, 4'd1));
  endtask

  // random line sequences with noise and occasional mode changes
  task automatic test_random_lines();
    int stop_at;
    stop_at = items_sent + 500;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0)
        configure($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 6) == 0) repeat ($urandom_range(5, 20)) send_item(rand_item());
      else run_line_sequence();
    end
  endtask

  // receiver holds off while offers keep coming, input must back up
  task automatic test_output_stall();
    configure(1'b1, 1'b0);
    send_item(command(CMD_START, 4'd0));
    hold_cycles = 300;
    repeat (12) send_item(offer(8'd60, 8'd70 + 8'($urandom_range(0, 7)),
                                8'($urandom_range(1, 167))));
    for (int s = 0; s < 10; s++) send_item(command(CMD_READ, 4'(s)));
  endtask

  // back to back traffic, no idling on either side
  task automatic test_steady_stream();
    configure(1'b1, 1'($urandom_range(0, 1)));
    idle_on = 1'b0;
    while (items_sent < 720) begin
      if ($urandom_range(0, 3) == 0) configure(1'b1, 1'($urandom_range(0, 1)));
      run_line_sequence();
    end
  endtask

  // receiver: random stalls and the long hold-off
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        n = hold_cycles;
        hold_cycles = 0;
        for (int c = 0; c < n; c++) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.accepted     = out_ch.accepted;
      got.sprite_count = out_ch.sprite_count;
      got.slot_valid   = out_ch.slot_valid;
      got.obj.y        = out_ch.out_y;
      got.obj.x        = out_ch.out_x;
      got.obj.tile     = out_ch.out_tile;
      got.obj.attr     = out_ch.out_attr;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing pending: acc %0b count %0d valid %0b obj %h",
                   $time, got.accepted, got.sprite_count, got.slot_valid, got.obj);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch exp/act acc %0b/%0b count %0d/%0d valid %0b/%0b",
                      " y %h/%h x %h/%h tile %h/%h attr %h/%h"}, $time,
                     want.accepted, got.accepted, want.sprite_count, got.sprite_count,
                     want.slot_valid, got.slot_valid, want.obj.y, got.obj.y,
                     want.obj.x, got.obj.x, want.obj.tile, got.obj.tile,
                     want.obj.attr, got.obj.attr);
        end
      end
    end
  end

  // longest run of an offered but refused input transfer
  always @(posedge clk) begin
    if (in_ch.valid && !in_ch.ready) stall_run++;
    else stall_run = 0;
    if (stall_run > longest_stall) longest_stall = stall_run;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("timeout with %0d results pending", expected_results.size());
    $display("sprite_line_select_sort_test: done, errors");
    $finish;
  end

  initial begin
    int waited;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_START;
    in_ch.line     <= '0;
    in_ch.obj_y    <= '0;
    in_ch.obj_x    <= '0;
    in_ch.obj_tile <= '0;
    in_ch.obj_attr <= '0;
    in_ch.slot     <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= REG_SPRITE_ENABLE;
    cfg_ch.data    <= '0;
    foreach (line_table[i]) line_table[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disabled_offers();
    test_screening_edges();
    test_tall_rows_and_ties();
    test_random_lines();
    test_output_stall();
    test_steady_stream();

    // let the last results come out
    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived", expected_results.size());
      mismatch_count += expected_results.size();
    end

    $display("%0d commands sent, %0d objects inserted, %0d table slots read back",
             items_sent, offers_inserted, slots_read);
    $display("longest input stall %0d cycles, %0d mismatches", longest_stall, mismatch_count);
    if (mismatch_count == 0)
      $display("sprite_line_select_sort_test: done, clean");
    else
      $display("sprite_line_select_sort_test: done, errors");
    $finish;
  end

endmodule
